### rtl/core/sis_pkg.sv
// sis_pkg: shared types and constants for the sorted id set.
// Used by sis_cell, sis_ctrl and sorted_id_set; depends on nothing.
package sis_pkg;

  localparam int ENTRIES = 128;
  localparam int ID_BITS = 22;
  localparam int POS_W   = $clog2(ENTRIES + 1);
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int OUT_W   = 8;

  localparam logic [POS_W-1:0] ENTRIES_P = POS_W'(ENTRIES);

  typedef logic [ID_BITS-1:0] id_t;
  typedef logic [POS_W-1:0]   pos_t;

  typedef enum logic [1:0] {
    MODE_QUERY  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_SRCH,
    ST_APPLY
  } state_t;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic cmp;
    logic ins;
    logic rem;
    id_t  key;
    pos_t pos;
    pos_t count;
  } cell_bus_t;

endpackage

### rtl/core/sis_cell.sv
// sis_cell: one slot of the sorted row; holds an id, compares it with the key
// and takes a neighbor's id on shifts. Depends on sis_pkg.
module sis_cell
  import sis_pkg::*;
(
  input  logic      clk,
  input  pos_t      idx,
  input  cell_bus_t bus,
  input  id_t       left_id,
  input  id_t       right_id,
  output id_t       id,
  output logic      lt,
  output logic      eq
);

  id_t  id_r;
  logic lt_r;
  logic eq_r;
  logic valid;

  assign valid = (idx < bus.count);

  always_ff @(posedge clk) begin
    if (bus.cmp) begin
      lt_r <= valid && (id_r < bus.key);
      eq_r <= valid && (id_r == bus.key);
    end
    if (bus.ins) begin
      if (idx == bus.pos) begin
        id_r <= bus.key;
      end else if (idx > bus.pos) begin
        id_r <= left_id;
      end
    end else if (bus.rem) begin
      if (idx >= bus.pos) begin
        id_r <= right_id;
      end
    end
  end

  assign id = id_r;
  assign lt = lt_r;
  assign eq = eq_r;

endmodule

### rtl/core/sis_ctrl.sv
// sis_ctrl: command sequencer, lower-bound search over the row's compare
// flags, occupancy count and result register. Depends on sis_pkg.
module sis_ctrl
  import sis_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_mode,
  input  id_t                in_ident,
  input  logic [ENTRIES-1:0] lt_vec,
  input  logic [ENTRIES-1:0] eq_vec,
  output logic               busy,
  output cell_bus_t          bus,
  output logic               out_strobe,
  output logic               out_found,
  output logic               out_changed,
  output logic               out_full_res,
  output logic [OUT_W-1:0]   out_position,
  output logic [OUT_W-1:0]   out_occupancy
);

  state_t state_r, state_nxt;
  mode_t  mode_r;
  id_t    key_r;
  pos_t   count_r, count_nxt;
  pos_t   pos_r, pos_s, cand;
  logic   found_r, found_s;
  logic   do_ins, do_rem, is_full;

  logic             strobe_r;
  logic             found_o_r, changed_o_r, full_o_r;
  logic [OUT_W-1:0] pos_o_r, occ_o_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_CMP;
      ST_CMP:   state_nxt = ST_SRCH;
      ST_SRCH:  state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // lower bound: binary search over the thermometer of lt flags
  always_comb begin
    pos_s = '0;
    cand  = '0;
    for (int b = POS_W - 1; b >= 0; b--) begin
      cand = pos_s | (POS_W'(1) << b);
      if ((cand <= ENTRIES_P) && lt_vec[IDX_W'(cand - POS_W'(1))]) begin
        pos_s = cand;
      end
    end
    found_s = |eq_vec;
  end

  always_comb begin
    is_full   = (mode_r == MODE_INSERT) && !found_r && (count_r == ENTRIES_P);
    do_ins    = (mode_r == MODE_INSERT) && !found_r && (count_r != ENTRIES_P);
    do_rem    = (mode_r == MODE_REMOVE) && found_r;
    count_nxt = count_r;
    if (mode_r == MODE_CLEAR) begin
      count_nxt = '0;
    end else if (do_ins) begin
      count_nxt = count_r + POS_W'(1);
    end else if (do_rem) begin
      count_nxt = count_r - POS_W'(1);
    end
  end

  // outputs of the sequencer
  always_comb begin
    busy      = 1'b0;
    bus.cmp   = 1'b0;
    bus.ins   = 1'b0;
    bus.rem   = 1'b0;
    bus.key   = key_r;
    bus.pos   = pos_r;
    bus.count = count_r;
    unique case (state_r)
      ST_IDLE:  busy = 1'b0;
      ST_CMP: begin
        busy    = 1'b1;
        bus.cmp = 1'b1;
      end
      ST_SRCH:  busy = 1'b1;
      ST_APPLY: begin
        busy    = 1'b1;
        bus.ins = do_ins;
        bus.rem = do_rem;
      end
      default:  busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == ST_APPLY);
      if (state_r == ST_APPLY) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && start) begin
      mode_r <= mode_t'(in_mode);
      key_r  <= in_ident;
    end
    if (state_r == ST_SRCH) begin
      pos_r   <= pos_s;
      found_r <= found_s;
    end
    if (state_r == ST_APPLY) begin
      if (mode_r == MODE_CLEAR) begin
        found_o_r   <= 1'b0;
        changed_o_r <= 1'b1;
        full_o_r    <= 1'b0;
        pos_o_r     <= '0;
      end else begin
        found_o_r   <= found_r;
        changed_o_r <= do_ins || do_rem;
        full_o_r    <= is_full;
        pos_o_r     <= OUT_W'(pos_r);
      end
      occ_o_r <= OUT_W'(count_nxt);
    end
  end

  assign out_strobe    = strobe_r;
  assign out_found     = found_o_r;
  assign out_changed   = changed_o_r;
  assign out_full_res  = full_o_r;
  assign out_position  = pos_o_r;
  assign out_occupancy = occ_o_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ENTRIES_P)
    else $error("occupancy above capacity");

  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH) |-> $onehot0(eq_vec))
    else $error("more than one cell matches the key");

  a_strobe_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == ST_APPLY))
    else $error("result beat without an apply step");

  a_full_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_full_res) |-> (!out_changed && !out_found))
    else $error("refused insert reported a change");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_APPLY) && (mode_r != MODE_CLEAR) && !do_ins && !do_rem)
      |=> (count_r == $past(count_r)))
    else $error("occupancy moved without an update");

endmodule

### rtl/core/sorted_id_set.sv
// sorted_id_set: a set of ids kept ascending in a row of cells, with query,
// insert, remove and clear commands. Depends on sis_pkg, sis_cell, sis_ctrl.
//
// Each command runs through these steps from the start beat to its result:
// a compare step in which every cell compares its id with the key, the
// lower-bound search over the cells' compare flags, an apply step in which
// the row shifts by one slot on an insert or remove that changes the set,
// and the result register. busy is high in the compare, search and apply
// steps; a new command is taken only while busy is low. The result shows on
// the out_ ports for exactly one cycle with out_strobe high; the receiver
// cannot stall it and must take it then. An insert of a new id into a full
// set is refused with out_full_res set. No clearing pass is needed after reset.
module sorted_id_set
  import sis_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [ID_BITS-1:0] in_ident,
  output logic               out_strobe,
  output logic               out_found,
  output logic               out_changed,
  output logic               out_full_res,
  output logic [OUT_W-1:0]   out_position,
  output logic [OUT_W-1:0]   out_occupancy
);

  cell_bus_t          bus;
  id_t                ids [ENTRIES];
  logic [ENTRIES-1:0] lt_vec;
  logic [ENTRIES-1:0] eq_vec;

  sis_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_mode       (in_mode),
    .in_ident      (in_ident),
    .lt_vec        (lt_vec),
    .eq_vec        (eq_vec),
    .busy          (busy),
    .bus           (bus),
    .out_strobe    (out_strobe),
    .out_found     (out_found),
    .out_changed   (out_changed),
    .out_full_res  (out_full_res),
    .out_position  (out_position),
    .out_occupancy (out_occupancy)
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    id_t left_id;
    id_t right_id;

    if (i == 0) begin : g_first
      assign left_id = '0;
    end else begin : g_mid_l
      assign left_id = ids[i-1];
    end

    if (i == ENTRIES - 1) begin : g_last
      assign right_id = '0;
    end else begin : g_mid_r
      assign right_id = ids[i+1];
    end

    sis_cell u_cell (
      .clk      (clk),
      .idx      (POS_W'(i)),
      .bus      (bus),
      .left_id  (left_id),
      .right_id (right_id),
      .id       (ids[i]),
      .lt       (lt_vec[i]),
      .eq       (eq_vec[i])
    );
  end

endmodule
